@@ src/ofss_pkg.sv @@
`timescale 1ns / 1ps

package ofss_pkg;

	// Storage depths of the order FIFO and the shelf stack.
	localparam int ORDER_DEPTH = 16;
	localparam int SHELF_DEPTH = 16;

	// Derived widths for indexes and occupancy counters.
	localparam int ORDER_IDX_W = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
	localparam int SHELF_IDX_W = (SHELF_DEPTH > 1) ? $clog2(SHELF_DEPTH) : 1;
	localparam int ORDER_CNT_W = $clog2(ORDER_DEPTH + 1);
	localparam int SHELF_CNT_W = $clog2(SHELF_DEPTH + 1);

	// Fixed field widths of the words.
	localparam int CMD_W   = 2;
	localparam int CODE_W  = 4;
	localparam int FILL_W  = 5;
	localparam int LIMIT_W = 5;
	localparam int CFG_IDX_W = 1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ORDER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAKE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BUY   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHELF_LIMIT = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // latch the incoming word
		logic single;   // execute an order, buy or no-op
		logic move;     // move one entry from FIFO head to stack top
		logic publish;  // load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_make;
		logic can_move;
		logic out_busy;
	} dp_sts_t;

	// One result word.
	typedef struct packed {
		logic              accepted;
		logic [CODE_W-1:0] bought_code;
		logic [FILL_W-1:0] moved_count;
		logic [CODE_W-1:0] head_code;
		logic              head_valid;
		logic [CODE_W-1:0] top_code;
		logic              top_valid;
		logic [FILL_W-1:0] order_fill;
		logic [FILL_W-1:0] shelf_fill;
	} result_t;

	// A limit of zero acts as one, and a limit above the depth acts as the depth.
	function automatic logic [31:0] eff_limit(input logic [LIMIT_W-1:0] lim,
			input logic [31:0] depth);
		logic [31:0] wide;
		wide = 32'(lim);
		if (wide == 32'd0) begin
			eff_limit = 32'd1;
		end else if (wide > depth) begin
			eff_limit = depth;
		end else begin
			eff_limit = wide;
		end
	endfunction

endpackage

@@ src/ofss_if.sv @@
`timescale 1ns / 1ps

// Command channel.
interface ofss_in_if;
	logic                        valid;
	logic                        ready;
	logic [ofss_pkg::CMD_W-1:0]  cmd;
	logic [ofss_pkg::CODE_W-1:0] item_code;

	modport source(output valid, cmd, item_code, input ready);
	modport sink(input valid, cmd, item_code, output ready);
endinterface

// Result channel.
interface ofss_out_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [ofss_pkg::CODE_W-1:0] bought_code;
	logic [ofss_pkg::FILL_W-1:0] moved_count;
	logic [ofss_pkg::CODE_W-1:0] head_code;
	logic                        head_valid;
	logic [ofss_pkg::CODE_W-1:0] top_code;
	logic                        top_valid;
	logic [ofss_pkg::FILL_W-1:0] order_fill;
	logic [ofss_pkg::FILL_W-1:0] shelf_fill;

	modport source(output valid, accepted, bought_code, moved_count, head_code, head_valid,
		top_code, top_valid, order_fill, shelf_fill, input ready);
	modport sink(input valid, accepted, bought_code, moved_count, head_code, head_valid,
		top_code, top_valid, order_fill, shelf_fill, output ready);
endinterface

@@ src/ofss_ctrl.sv @@
`timescale 1ns / 1ps

module ofss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ofss_pkg::dp_sts_t sts,
	output ofss_pkg::dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_MOVE = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_make) begin
					state_d = ST_MOVE;
				end else begin
					cmd.single = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_MOVE: begin
				if (sts.can_move) begin
					cmd.move = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/ofss_dp.sv @@
`timescale 1ns / 1ps

module ofss_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [ofss_pkg::CMD_W-1:0]           in_cmd,
	input  logic [ofss_pkg::CODE_W-1:0]          in_item_code,
	input  logic                                 cfg_we,
	input  logic [ofss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ofss_pkg::LIMIT_W-1:0]         cfg_wdata,
	input  ofss_pkg::dp_cmd_t                    cmd,
	output ofss_pkg::dp_sts_t                    sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output ofss_pkg::result_t                    res
);

	// Item storage.
	logic [ofss_pkg::CODE_W-1:0] order_store [ofss_pkg::ORDER_DEPTH];
	logic [ofss_pkg::CODE_W-1:0] shelf_store [ofss_pkg::SHELF_DEPTH];

	logic [ofss_pkg::CMD_W-1:0]       cmd_q;
	logic [ofss_pkg::CODE_W-1:0]      code_q;
	logic [ofss_pkg::ORDER_IDX_W-1:0] head_q;
	logic [ofss_pkg::ORDER_IDX_W-1:0] tail_q;
	logic [ofss_pkg::ORDER_CNT_W-1:0] order_cnt_q;
	logic [ofss_pkg::SHELF_CNT_W-1:0] shelf_cnt_q;
	logic [ofss_pkg::SHELF_CNT_W-1:0] moved_q;
	logic                             accepted_q;
	logic [ofss_pkg::CODE_W-1:0]      bought_q;
	logic [ofss_pkg::LIMIT_W-1:0]     order_limit_q;
	logic [ofss_pkg::LIMIT_W-1:0]     shelf_limit_q;
	logic                             out_valid_q;
	ofss_pkg::result_t                res_q;

	logic                             order_full;
	logic                             shelf_full;
	logic [ofss_pkg::SHELF_CNT_W-1:0] top_cnt;
	logic [ofss_pkg::SHELF_IDX_W-1:0] top_idx;
	logic [ofss_pkg::SHELF_IDX_W-1:0] push_idx;
	logic [ofss_pkg::ORDER_IDX_W-1:0] head_next;
	logic [ofss_pkg::ORDER_IDX_W-1:0] tail_next;
	logic [ofss_pkg::CODE_W-1:0]      head_code;
	logic [ofss_pkg::CODE_W-1:0]      top_code;

	// Occupancy against the effective limits.
	assign order_full = 32'(order_cnt_q) >=
		ofss_pkg::eff_limit(order_limit_q, 32'(ofss_pkg::ORDER_DEPTH));
	assign shelf_full = 32'(shelf_cnt_q) >=
		ofss_pkg::eff_limit(shelf_limit_q, 32'(ofss_pkg::SHELF_DEPTH));

	// Pointer arithmetic with circular wrap on the FIFO.
	assign top_cnt   = shelf_cnt_q - 1'b1;
	assign top_idx   = top_cnt[ofss_pkg::SHELF_IDX_W-1:0];
	assign push_idx  = shelf_cnt_q[ofss_pkg::SHELF_IDX_W-1:0];
	assign head_next = (head_q == ofss_pkg::ORDER_IDX_W'(ofss_pkg::ORDER_DEPTH - 1)) ?
		'0 : head_q + 1'b1;
	assign tail_next = (tail_q == ofss_pkg::ORDER_IDX_W'(ofss_pkg::ORDER_DEPTH - 1)) ?
		'0 : tail_q + 1'b1;
	assign head_code = order_store[head_q];
	assign top_code  = shelf_store[top_idx];

	// Status toward the controller.
	assign sts.is_make  = (cmd_q == ofss_pkg::CMD_MAKE);
	assign sts.can_move = (order_cnt_q != '0) && !shelf_full;
	assign sts.out_busy = out_valid_q && !out_ready;

	// Store writes and the latched command word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_cmd;
			code_q <= in_item_code;
		end
		if (cmd.single && (cmd_q == ofss_pkg::CMD_ORDER) && !order_full) begin
			order_store[tail_q] <= code_q;
		end
		if (cmd.move) begin
			shelf_store[push_idx] <= head_code;
		end
	end

	// Pointers, counters and per-word outcome.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			order_cnt_q <= '0;
			shelf_cnt_q <= '0;
			moved_q     <= '0;
			accepted_q  <= 1'b0;
			bought_q    <= '0;
		end else begin
			if (cmd.load) begin
				moved_q    <= '0;
				accepted_q <= 1'b0;
				bought_q   <= '0;
			end
			if (cmd.single) begin
				case (cmd_q)
					ofss_pkg::CMD_ORDER: begin
						if (!order_full) begin
							tail_q      <= tail_next;
							order_cnt_q <= order_cnt_q + 1'b1;
							accepted_q  <= 1'b1;
						end
					end
					ofss_pkg::CMD_BUY: begin
						if (shelf_cnt_q != '0) begin
							shelf_cnt_q <= top_cnt;
							bought_q    <= top_code;
							accepted_q  <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.move) begin
				head_q      <= head_next;
				order_cnt_q <= order_cnt_q - 1'b1;
				shelf_cnt_q <= shelf_cnt_q + 1'b1;
				moved_q     <= moved_q + 1'b1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_limit_q <= ofss_pkg::LIMIT_W'(16);
			shelf_limit_q <= ofss_pkg::LIMIT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				ofss_pkg::CFG_ORDER_LIMIT: order_limit_q <= cfg_wdata;
				ofss_pkg::CFG_SHELF_LIMIT: shelf_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload, taken from the state after the word's work.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res_q.accepted    <= accepted_q;
			res_q.bought_code <= bought_q;
			res_q.moved_count <= ofss_pkg::FILL_W'(moved_q);
			res_q.head_valid  <= (order_cnt_q != '0);
			res_q.head_code   <= (order_cnt_q != '0) ? head_code : '0;
			res_q.top_valid   <= (shelf_cnt_q != '0);
			res_q.top_code    <= (shelf_cnt_q != '0) ? top_code : '0;
			res_q.order_fill  <= ofss_pkg::FILL_W'(order_cnt_q);
			res_q.shelf_fill  <= ofss_pkg::FILL_W'(shelf_cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ src/order_fifo_to_shelf_stack_unit.sv @@
`timescale 1ns / 1ps

// Order FIFO feeding a shelf stack. Each command word (order, make, buy or the unused code) yields one
// result word with the outcome and the FIFO and stack status after the command.
// Order, buy and the unused code go from acceptance through the execute state and the done
// state to the result register; make also runs the single-entry transfer loop between the
// FIFO and the stack storage until the FIFO is empty or the stack is full. A new
// command is accepted while a finished result still waits on the result channel.
// Limits written through the configuration port apply once registered, also to a command in progress;
// a limit of zero acts as one and a limit above the depth acts as the depth.

module order_fifo_to_shelf_stack_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	ofss_in_if.sink                          in_ch,
	ofss_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [ofss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ofss_pkg::LIMIT_W-1:0]     cfg_wdata
);

	ofss_pkg::dp_cmd_t dp_cmd;
	ofss_pkg::dp_sts_t dp_sts;
	ofss_pkg::result_t res;

	// Sequencer.
	ofss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// Storage, counters and result register.
	ofss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_cmd       (in_ch.cmd),
		.in_item_code (in_ch.item_code),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (dp_cmd),
		.sts          (dp_sts),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.res          (res)
	);

	// Result word onto the channel.
	assign out_ch.accepted    = res.accepted;
	assign out_ch.bought_code = res.bought_code;
	assign out_ch.moved_count = res.moved_count;
	assign out_ch.head_code   = res.head_code;
	assign out_ch.head_valid  = res.head_valid;
	assign out_ch.top_code    = res.top_code;
	assign out_ch.top_valid   = res.top_valid;
	assign out_ch.order_fill  = res.order_fill;
	assign out_ch.shelf_fill  = res.shelf_fill;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	// Command code that the block treats as a no-op.
	localparam logic [ofss_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
	// Quiet cycles after the last result before a limit write or the final verdict.
	localparam int SETTLE_CYCLES = 24;
	// Cycles without any handshake before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 16;
	localparam int WORDS_PER_PHASE = 100;

	typedef struct packed {
		logic [ofss_pkg::CMD_W-1:0]  cmd;
		logic [ofss_pkg::CODE_W-1:0] code;
	} cmd_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ofss_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ofss_pkg::LIMIT_W-1:0] cfg_wdata;

	ofss_in_if in_ch();
	ofss_out_if out_ch();

	order_fifo_to_shelf_stack_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the FIFO, the stack and the limit registers.
	logic [ofss_pkg::CODE_W-1:0] order_mem [ofss_pkg::ORDER_DEPTH];
	logic [ofss_pkg::CODE_W-1:0] shelf_mem [ofss_pkg::SHELF_DEPTH];
	int order_hd;
	int order_tl;
	int order_cnt;
	int shelf_cnt;
	int order_lim;
	int shelf_lim;

	cmd_word_t cmd_backlog[$];
	ofss_pkg::result_t status_due[$];
	ofss_pkg::result_t want_r;

	int fail_count;
	int hang_count;
	logic in_fire;
	int send_gap;
	int recv_gap;
	logic send_steady;
	logic recv_steady;

	// Limit value that actually applies for a given register setting.
	function automatic int limit_in_use(input int lim, input int depth);
		if (lim == 0) begin
			return 1;
		end else if (lim > depth) begin
			return depth;
		end
		return lim;
	endfunction

	// Idle length: mostly zero or short, now and then long, none during steady stretches.
	function automatic int pick_gap(input logic steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Apply one command to the shadow state and queue the status word it should produce.
	task automatic apply_command(input logic [ofss_pkg::CMD_W-1:0] op,
			input logic [ofss_pkg::CODE_W-1:0] code);
		ofss_pkg::result_t r;
		int o_cap;
		int s_cap;
		r = '0;
		o_cap = limit_in_use(order_lim, ofss_pkg::ORDER_DEPTH);
		s_cap = limit_in_use(shelf_lim, ofss_pkg::SHELF_DEPTH);
		case (op)
			ofss_pkg::CMD_ORDER: begin
				if (order_cnt < o_cap) begin
					order_mem[order_tl] = code;
					order_tl = (order_tl + 1) % ofss_pkg::ORDER_DEPTH;
					order_cnt++;
					r.accepted = 1'b1;
				end
			end
			ofss_pkg::CMD_MAKE: begin
				while (order_cnt > 0 && shelf_cnt < s_cap) begin
					shelf_mem[shelf_cnt] = order_mem[order_hd];
					shelf_cnt++;
					order_hd = (order_hd + 1) % ofss_pkg::ORDER_DEPTH;
					order_cnt--;
					r.moved_count = r.moved_count + 1'b1;
				end
			end
			ofss_pkg::CMD_BUY: begin
				if (shelf_cnt > 0) begin
					shelf_cnt--;
					r.bought_code = shelf_mem[shelf_cnt];
					r.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.head_valid = (order_cnt > 0);
		r.head_code = (order_cnt > 0) ? order_mem[order_hd] : '0;
		r.top_valid = (shelf_cnt > 0);
		r.top_code = (shelf_cnt > 0) ? shelf_mem[shelf_cnt - 1] : '0;
		r.order_fill = ofss_pkg::FILL_W'(order_cnt);
		r.shelf_fill = ofss_pkg::FILL_W'(shelf_cnt);
		status_due.push_back(r);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic queue_word(input logic [ofss_pkg::CMD_W-1:0] op,
			input logic [ofss_pkg::CODE_W-1:0] code);
		cmd_word_t w;
		w.cmd = op;
		w.code = code;
		cmd_backlog.push_back(w);
	endtask

	// Wait until every word has gone in and every status word has come back.
	// The check runs at the rising edge, where the driver's updates have settled.
	task automatic drain_all();
		@(posedge clk);
		while (cmd_backlog.size() != 0 || in_ch.valid || status_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both limit registers while the block is quiet.
	task automatic set_limits(input int o_lim, input int s_lim);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ofss_pkg::CFG_ORDER_LIMIT;
		cfg_wdata <= ofss_pkg::LIMIT_W'(o_lim);
		@(negedge clk);
		cfg_index <= ofss_pkg::CFG_SHELF_LIMIT;
		cfg_wdata <= ofss_pkg::LIMIT_W'(s_lim);
		@(negedge clk);
		cfg_we <= 1'b0;
		order_lim = o_lim;
		shelf_lim = s_lim;
	endtask

	// One random phase; the order share varies so the stores both fill and drain.
	task automatic queue_random_phase(input int count);
		int w_ord;
		int w_make;
		int r;
		logic [ofss_pkg::CMD_W-1:0] op;
		w_ord = $urandom_range(25, 65);
		w_make = $urandom_range(10, 25);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_ord) begin
				op = ofss_pkg::CMD_ORDER;
			end else if (r < w_ord + w_make) begin
				op = ofss_pkg::CMD_MAKE;
			end else if (r < 96) begin
				op = ofss_pkg::CMD_BUY;
			end else begin
				op = CMD_NOP;
			end
			queue_word(op, ofss_pkg::CODE_W'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Command driver: holds a word until it is taken, then idles for a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_fire) begin
			// Word not yet taken; keep it steady.
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			in_ch.valid <= 1'b0;
		end else if (cmd_backlog.size() != 0) begin
			in_ch.valid <= 1'b1;
			in_ch.cmd <= cmd_backlog[0].cmd;
			in_ch.item_code <= cmd_backlog[0].code;
			cmd_backlog.pop_front();
			send_gap <= pick_gap(send_steady);
			if ($urandom_range(0, 49) == 0) begin
				send_steady <= ~send_steady;
			end
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Every command word taken by the block is predicted at the edge it is taken.
	always @(posedge clk) begin
		in_fire <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			apply_command(in_ch.cmd, in_ch.item_code);
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				recv_gap <= pick_gap(recv_steady);
			end
			if ($urandom_range(0, 49) == 0) begin
				recv_steady <= ~recv_steady;
			end
		end
	end

	// Result checker: each status word is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (status_due.size() == 0) begin
				$error("unexpected status word: nothing is waiting");
				fail_count++;
			end else begin
				want_r = status_due.pop_front();
				check_field("accepted", want_r.accepted, out_ch.accepted);
				check_field("bought_code", want_r.bought_code, out_ch.bought_code);
				check_field("moved_count", want_r.moved_count, out_ch.moved_count);
				check_field("head_code", want_r.head_code, out_ch.head_code);
				check_field("head_valid", want_r.head_valid, out_ch.head_valid);
				check_field("top_code", want_r.top_code, out_ch.top_code);
				check_field("top_valid", want_r.top_valid, out_ch.top_valid);
				check_field("order_fill", want_r.order_fill, out_ch.order_fill);
				check_field("shelf_fill", want_r.shelf_fill, out_ch.shelf_fill);
			end
		end
	end

	// Hang detector: counts cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			hang_count <= 0;
		end else if (hang_count >= HANG_LIMIT) begin
			$display("order_fifo_to_shelf_stack_unit regression: fail");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

	initial begin
		int o_plan [9];
		int s_plan [9];
		o_plan = '{16, 1, 0, 31, 17, 4, 12, 16, 1};
		s_plan = '{16, 1, 0, 31, 20, 12, 4, 1, 16};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.item_code = '0;
		out_ch.ready = 1'b0;
		in_fire = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		fail_count = 0;
		hang_count = 0;
		order_hd = 0;
		order_tl = 0;
		order_cnt = 0;
		shelf_cnt = 0;
		order_lim = 16;
		shelf_lim = 16;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Small limits: empty buy and make, no-op code, refused order, full stack.
		set_limits(3, 2);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		queue_word(ofss_pkg::CMD_MAKE, 4'd15);
		queue_word(CMD_NOP, 4'd15);
		queue_word(ofss_pkg::CMD_ORDER, 4'd0);
		queue_word(ofss_pkg::CMD_ORDER, 4'd15);
		queue_word(ofss_pkg::CMD_ORDER, 4'd10);
		queue_word(ofss_pkg::CMD_ORDER, 4'd5);
		queue_word(ofss_pkg::CMD_MAKE, 4'd0);
		queue_word(ofss_pkg::CMD_MAKE, 4'd0);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		queue_word(ofss_pkg::CMD_MAKE, 4'd0);
		drain_all();

		// Fill at full size, then lower both limits below the held fill.
		set_limits(16, 16);
		for (int i = 0; i < 5; i++) begin
			queue_word(ofss_pkg::CMD_ORDER, 4'd3 + 4'(i * 3));
		end
		queue_word(ofss_pkg::CMD_MAKE, 4'd0);
		for (int i = 0; i < 3; i++) begin
			queue_word(ofss_pkg::CMD_ORDER, 4'd9 - 4'(i));
		end
		drain_all();
		set_limits(2, 2);
		queue_word(ofss_pkg::CMD_ORDER, 4'd12);
		queue_word(ofss_pkg::CMD_MAKE, 4'd0);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		queue_word(ofss_pkg::CMD_BUY, 4'd0);
		drain_all();

		// Random phases: planned extremes first, then random limit settings.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 9) begin
				set_limits(o_plan[p], s_plan[p]);
			end else begin
				set_limits($urandom_range(0, 31), $urandom_range(0, 31));
			end
			queue_random_phase(WORDS_PER_PHASE);
			drain_all();
		end

		if (status_due.size() != 0) begin
			$error("%0d status words never arrived", status_due.size());
			fail_count += status_due.size();
		end
		if (fail_count == 0) begin
			$display("order_fifo_to_shelf_stack_unit regression: pass");
		end else begin
			$display("order_fifo_to_shelf_stack_unit regression: fail");
		end
		$finish;
	end

endmodule
